### design/mttt_pkg.sv
// ----------------------------------------------------------------------------
// mttt_pkg: shared constants and types for the multi timer tick table
// Table depth, index widths, command/result codes, and the control and
// status structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package mttt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = $clog2(NUM_TIMERS);
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_ADD     = 1'b1;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic load;
        logic add;
        logic step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic fire;
        logic pend_valid;
        logic out_free;
    } dp_stat_t;

endpackage

### design/mttt_ctrl.sv
// ----------------------------------------------------------------------------
// mttt_ctrl: sequencing state machine
// Accepts one command word at a time, drives the add, scan and commit steps
// of the datapath and holds off while the result register is occupied.
// ----------------------------------------------------------------------------
module mttt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                command,
    output logic                cmd_stall,
    input  mttt_pkg::dp_stat_t  stat,
    output mttt_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        IDLE,
        ADD,
        SCAN,
        FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            IDLE:
            begin
                if (cmd_valid && !stall_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = (command == mttt_pkg::CMD_ADD) ? ADD : SCAN;
                end
            end
            ADD:
            begin
                if (stat.out_free)
                begin
                    cmd.add    = 1'b1;
                    state_next = IDLE;
                end
            end
            SCAN:
            begin
                if (stat.scan_end)
                begin
                    state_next = FLUSH;
                end
                else if (!(stat.fire && stat.pend_valid && !stat.out_free))
                begin
                    cmd.step = 1'b1;
                end
            end
            FLUSH:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != IDLE);
        end
    end

    assign cmd_stall = stall_reg;

    a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !stall_reg |-> state_reg == IDLE)
        else $error("stall low outside idle");

endmodule

### design/mttt_dp.sv
// ----------------------------------------------------------------------------
// mttt_dp: timer table datapath
// Compacted timer table with fill count, scan read/write pointers, the
// pending fired result and the output result register.
// ----------------------------------------------------------------------------
module mttt_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  mttt_pkg::ctrl_cmd_t cmd,
    output mttt_pkg::dp_stat_t  stat,
    input  logic [15:0]         period,
    input  logic [31:0]         tag,
    input  logic                repeat_req,
    output logic                res_valid,
    input  logic                res_stall,
    output logic                kind,
    output logic [31:0]         fired_tag,
    output logic                status,
    output logic                last
);

    logic [15:0] period_mem_reg [mttt_pkg::NUM_TIMERS];
    logic [15:0] count_mem_reg  [mttt_pkg::NUM_TIMERS];
    logic [31:0] tag_mem_reg    [mttt_pkg::NUM_TIMERS];
    logic        rep_mem_reg    [mttt_pkg::NUM_TIMERS];

    logic [mttt_pkg::CNT_W-1:0] fill_reg;
    logic [mttt_pkg::CNT_W-1:0] rd_ptr_reg;
    logic [mttt_pkg::CNT_W-1:0] wr_ptr_reg;
    logic                       pend_valid_reg;
    logic [31:0]                pend_tag_reg;
    logic [15:0]                period_in_reg;
    logic [31:0]                tag_in_reg;
    logic                       rep_in_reg;

    logic        res_valid_reg;
    logic        kind_reg;
    logic [31:0] fired_tag_reg;
    logic        status_reg;
    logic        last_reg;

    logic [mttt_pkg::IDX_W-1:0] rd_idx;
    logic [15:0]                count_inc;
    logic                       fire;
    logic                       keep;
    logic                       full;
    logic                       out_free;
    logic                       push;

    logic                       wr_en;
    logic [mttt_pkg::IDX_W-1:0] wr_idx;
    logic [15:0]                wr_period;
    logic [15:0]                wr_count;
    logic [31:0]                wr_tag;
    logic                       wr_rep;

    assign rd_idx    = rd_ptr_reg[mttt_pkg::IDX_W-1:0];
    assign count_inc = count_mem_reg[rd_idx] + 16'd1;
    assign fire      = (period_mem_reg[rd_idx] != 16'd0)
                       && (count_inc == period_mem_reg[rd_idx]);
    assign keep      = !fire || rep_mem_reg[rd_idx];
    assign full      = (fill_reg == mttt_pkg::CNT_W'(mttt_pkg::NUM_TIMERS));
    assign out_free  = !res_valid_reg || !res_stall;
    assign push      = cmd.add || (cmd.step && fire && pend_valid_reg)
                       || (cmd.commit && pend_valid_reg);

    assign stat.scan_end   = (rd_ptr_reg == fill_reg);
    assign stat.fire       = fire;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = out_free;

    always_comb
    begin
        wr_en     = 1'b0;
        wr_idx    = fill_reg[mttt_pkg::IDX_W-1:0];
        wr_period = period_in_reg;
        wr_count  = 16'd0;
        wr_tag    = tag_in_reg;
        wr_rep    = rep_in_reg;
        if (cmd.add && !full)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.step && keep)
        begin
            wr_en     = 1'b1;
            wr_idx    = wr_ptr_reg[mttt_pkg::IDX_W-1:0];
            wr_period = period_mem_reg[rd_idx];
            wr_count  = fire ? 16'd0 : count_inc;
            wr_tag    = tag_mem_reg[rd_idx];
            wr_rep    = rep_mem_reg[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            period_mem_reg[wr_idx] <= wr_period;
            count_mem_reg[wr_idx]  <= wr_count;
            tag_mem_reg[wr_idx]    <= wr_tag;
            rep_mem_reg[wr_idx]    <= wr_rep;
        end
        if (cmd.load)
        begin
            period_in_reg <= period;
            tag_in_reg    <= tag;
            rep_in_reg    <= repeat_req;
        end
        if (cmd.step && fire)
        begin
            pend_tag_reg <= tag_mem_reg[rd_idx];
        end
        if (push)
        begin
            if (cmd.add)
            begin
                kind_reg      <= mttt_pkg::KIND_STATUS;
                fired_tag_reg <= 32'd0;
                status_reg    <= full ? mttt_pkg::STATUS_FULL : mttt_pkg::STATUS_OK;
                last_reg      <= 1'b1;
            end
            else
            begin
                kind_reg      <= mttt_pkg::KIND_FIRED;
                fired_tag_reg <= pend_tag_reg;
                status_reg    <= mttt_pkg::STATUS_OK;
                last_reg      <= cmd.commit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            if (cmd.load)
            begin
                rd_ptr_reg     <= '0;
                wr_ptr_reg     <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
                if (keep)
                begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
                if (fire)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            else if (cmd.commit)
            begin
                fill_reg       <= wr_ptr_reg;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.add && !full)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign kind      = kind_reg;
    assign fired_tag = fired_tag_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= mttt_pkg::CNT_W'(mttt_pkg::NUM_TIMERS))
        else $error("fill count out of range");

    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg <= rd_ptr_reg)
        else $error("compaction pointer ahead of scan pointer");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result overwritten while stalled");

    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !pend_valid_reg && rd_ptr_reg == '0)
        else $error("scan state not cleared on new word");

endmodule

### design/multi_timer_tick_table_core.sv
// ----------------------------------------------------------------------------
// multi_timer_tick_table_core: table of software timers
// Usage:
//   Command channel (cmd_valid/cmd_stall) takes one word: command, period,
//   tag, repeat_req. An add word appends a timer and returns one status
//   word (status 1 when the table is full). A tick word advances every
//   timer; each timer that reaches its period returns a fired word with its
//   tag, in table order, and one-shot timers drop out of the table.
//   Result channel (res_valid/res_stall) carries kind, fired_tag, status and
//   last; last marks the final result word of a command word. A tick with no
//   timer due returns nothing.
// Timing:
//   One command word at a time. An add runs load then add; a tick runs
//   load, a scan step per stored timer, end check and commit. An add's
//   status word is registered in the add step, which waits while the
//   result register is occupied; a fired word waits for the next due timer
//   or the end of the scan.
//   Result stall holds the scan whenever a new result word is ready and the
//   result register is still occupied; no word is dropped.
// Reset:
//   rst_n clears the table to empty and the result channel to idle.
// ----------------------------------------------------------------------------
module multi_timer_tick_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic        command,
    input  logic [15:0] period,
    input  logic [31:0] tag,
    input  logic        repeat_req,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        kind,
    output logic [31:0] fired_tag,
    output logic        status,
    output logic        last
);

    mttt_pkg::ctrl_cmd_t cmd;
    mttt_pkg::dp_stat_t  stat;

    mttt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .command   (command),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    mttt_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .period     (period),
        .tag        (tag),
        .repeat_req (repeat_req),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .kind       (kind),
        .fired_tag  (fired_tag),
        .status     (status),
        .last       (last)
    );

endmodule

### tb/tb_multi_timer_tick_table_core.sv
// ----------------------------------------------------------------------------
// tb_multi_timer_tick_table_core: self-checking bench for the timer table
// Drives add and tick command words and predicts every status and fired
// result word with a behavioral copy of the timer list. A short directed
// part covers the field extremes, a period of zero, one-shot removal, a
// full table and a tick where many timers are due. It is followed by
// randomized traffic with idle and stall bursts, one long result hold-off
// and one drain pause.
// ----------------------------------------------------------------------------
module tb_multi_timer_tick_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_WORDS  = 320;
    localparam int QUIET_WORDS   = 40;
    localparam int LONG_HOLD     = 150;
    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = mttt_pkg::NUM_TIMERS + 8;
    localparam int MAX_REPORTS   = 30;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cmd_valid  = 1'b0;
    logic        command    = mttt_pkg::CMD_TICK;
    logic [15:0] period     = '0;
    logic [31:0] tag        = '0;
    logic        repeat_req = 1'b0;
    logic        res_stall  = 1'b0;
    logic        cmd_stall;
    logic        res_valid;
    logic        kind;
    logic [31:0] fired_tag;
    logic        status;
    logic        last;

    bit hold_ask = 1'b0;
    bit quiet    = 1'b0;
    int idle_cycles = 0;

    class timer_list_tracker;
        typedef struct {
            logic        kind;
            logic [31:0] fired_tag;
            logic        status;
            logic        last;
        } result_word_t;

        logic        in_use   [mttt_pkg::NUM_TIMERS];
        logic [15:0] reload   [mttt_pkg::NUM_TIMERS];
        logic [15:0] elapsed  [mttt_pkg::NUM_TIMERS];
        logic [31:0] label    [mttt_pkg::NUM_TIMERS];
        logic        periodic [mttt_pkg::NUM_TIMERS];

        result_word_t owed_results[$];

        int errors;
        int words;
        int results;
        int firings;
        int refused;

        function new();
            for (int i = 0; i < mttt_pkg::NUM_TIMERS; i++)
                clear_slot(i);
            errors  = 0;
            words   = 0;
            results = 0;
            firings = 0;
            refused = 0;
        endfunction

        function void clear_slot(int i);
            in_use[i]   = 1'b0;
            reload[i]   = '0;
            elapsed[i]  = '0;
            label[i]    = '0;
            periodic[i] = 1'b0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // accepted command word: update the list and queue its result words
        function void apply_command(logic c, logic [15:0] p, logic [31:0] t, logic r);
            result_word_t batch[$];
            result_word_t rw;
            int           free_idx;
            int           w;
            logic         keep;
            words++;
            if (c == mttt_pkg::CMD_ADD)
            begin
                free_idx = -1;
                for (int i = 0; i < mttt_pkg::NUM_TIMERS; i++)
                    if (!in_use[i] && free_idx < 0)
                        free_idx = i;
                rw.kind      = mttt_pkg::KIND_STATUS;
                rw.fired_tag = '0;
                rw.last      = 1'b1;
                if (free_idx < 0)
                begin
                    rw.status = mttt_pkg::STATUS_FULL;
                    refused++;
                end
                else
                begin
                    rw.status          = mttt_pkg::STATUS_OK;
                    in_use[free_idx]   = 1'b1;
                    reload[free_idx]   = p;
                    elapsed[free_idx]  = '0;
                    label[free_idx]    = t;
                    periodic[free_idx] = r;
                end
                owed_results.push_back(rw);
            end
            else
            begin
                w = 0;
                for (int i = 0; i < mttt_pkg::NUM_TIMERS; i++)
                begin
                    if (in_use[i])
                    begin
                        keep       = 1'b1;
                        elapsed[i] = elapsed[i] + 16'd1;
                        if (reload[i] != 16'd0 && elapsed[i] == reload[i])
                        begin
                            rw.kind      = mttt_pkg::KIND_FIRED;
                            rw.fired_tag = label[i];
                            rw.status    = mttt_pkg::STATUS_OK;
                            rw.last      = 1'b0;
                            batch.push_back(rw);
                            elapsed[i] = '0;
                            keep       = periodic[i];
                        end
                        if (keep)
                        begin
                            in_use[w]   = 1'b1;
                            reload[w]   = reload[i];
                            elapsed[w]  = elapsed[i];
                            label[w]    = label[i];
                            periodic[w] = periodic[i];
                            w++;
                        end
                    end
                end
                for (int i = w; i < mttt_pkg::NUM_TIMERS; i++)
                    clear_slot(i);
                if (batch.size() > 0)
                    batch[batch.size() - 1].last = 1'b1;
                foreach (batch[k])
                    owed_results.push_back(batch[k]);
                firings += batch.size();
            end
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        endfunction

        function void match_result(logic k, logic [31:0] ft, logic s, logic l);
            result_word_t want;
            results++;
            if (owed_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result word, expected none, actual kind %0d tag %h",
                             $time, k, ft);
                return;
            end
            want = owed_results.pop_front();
            if (want.kind !== k)
                report("kind", want.kind, k);
            if (want.fired_tag !== ft)
                report("fired_tag", want.fired_tag, ft);
            if (want.status !== s)
                report("status", want.status, s);
            if (want.last !== l)
                report("last", want.last, l);
        endfunction
    endclass

    timer_list_tracker tracker;

    multi_timer_tick_table_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .command    (command),
        .period     (period),
        .tag        (tag),
        .repeat_req (repeat_req),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .kind       (kind),
        .fired_tag  (fired_tag),
        .status     (status),
        .last       (last)
    );

    always #5 clk = ~clk;

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(logic c, logic [15:0] p, logic [31:0] t, logic r);
        cmd_valid  <= 1'b1;
        command    <= c;
        period     <= p;
        tag        <= t;
        repeat_req <= r;
        do
            @(posedge clk);
        while (cmd_stall);
        tracker.apply_command(c, p, t, r);
        @(negedge clk);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    task automatic wait_drain();
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (tracker.pending() != 0);
    endtask

    // mostly one-shot timers with short periods so the list keeps turning over
    task automatic send_random_word();
        logic [15:0] p;
        int          pick;
        pick = $urandom_range(0, 63);
        if ($urandom_range(0, 99) < 55)
            send_word(mttt_pkg::CMD_TICK, 16'($urandom), $urandom, 1'($urandom));
        else
        begin
            if (pick == 0)
                p = 16'd0;
            else if (pick < 7)
                p = 16'($urandom_range(13, 200));
            else
                p = 16'($urandom_range(1, 12));
            send_word(mttt_pkg::CMD_ADD, p, $urandom, $urandom_range(0, 19) == 0);
        end
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_ask)
            begin
                hold_ask   = 1'b0;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 11) == 0)
                stall_left = $urandom_range(1, 18);
            res_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
        if (rst_n && res_valid && !res_stall)
            tracker.match_result(kind, fired_tag, status, last);

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        tracker = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_word(mttt_pkg::CMD_ADD, 16'd1, 32'hFFFF_FFFF, 1'b1);
        send_word(mttt_pkg::CMD_ADD, 16'd0, 32'h0000_0000, 1'b0);
        send_word(mttt_pkg::CMD_ADD, 16'hFFFF, $urandom, 1'b1);
        send_word(mttt_pkg::CMD_ADD, 16'd2, 32'hA5A5_5A5A, 1'b0);
        repeat (3)
        begin
            sender_gap();
            send_word(mttt_pkg::CMD_TICK, 16'h0000, 32'h0000_0000, 1'b0);
        end
        // fill the list, then one add past full
        for (int i = 0; i < mttt_pkg::NUM_TIMERS - 2; i++)
            send_word(mttt_pkg::CMD_ADD, 16'd1, $urandom, 1'b0);
        // every timer but two due at once; payload ignored on a tick
        send_word(mttt_pkg::CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        wait_drain();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 3)
                hold_ask = 1'b1;
            if (n == RANDOM_WORDS / 2)
                wait_drain();
            if (n == RANDOM_WORDS - QUIET_WORDS)
                quiet = 1'b1;
            sender_gap();
            send_random_word();
        end
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Ran %0d command words and checked %0d result words.",
                 tracker.words, tracker.results);
        $display("Saw %0d timer firings and %0d adds refused on a full list.",
                 tracker.firings, tracker.refused);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
design/mttt_pkg.sv
design/mttt_ctrl.sv
design/mttt_dp.sv
design/multi_timer_tick_table_core.sv
tb/tb_multi_timer_tick_table_core.sv
